// ===== sv/wsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the wiper sequencer with knob sensor check.
// No dependencies; imported by every module of the block.
package wsc_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int FILTER_DEPTH = 8;
  localparam int SLOT_BITS    = $clog2(FILTER_DEPTH);
  localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
  localparam int TICK_MS      = 10;
  localparam int MILLIS_BITS  = 12;
  localparam int DUTY_BITS    = 12;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 12;

  localparam logic [SAMPLE_BITS-1:0] LVL_INT  = SAMPLE_BITS'(500);
  localparam logic [SAMPLE_BITS-1:0] LVL_LOW  = SAMPLE_BITS'(2000);
  localparam logic [SAMPLE_BITS-1:0] LVL_HIGH = SAMPLE_BITS'(3500);

  localparam logic [SAMPLE_BITS-1:0] MIN_SAFE_RST   = SAMPLE_BITS'(50);
  localparam logic [SAMPLE_BITS-1:0] MAX_SAFE_RST   = SAMPLE_BITS'(4040);
  localparam logic [SAMPLE_BITS-1:0] STEP_LIMIT_RST = SAMPLE_BITS'(1500);

  localparam logic [DUTY_BITS-1:0] DUTY_REST  = DUTY_BITS'(800);
  localparam logic [DUTY_BITS-1:0] DUTY_SWEEP = DUTY_BITS'(3300);

  localparam logic [MILLIS_BITS-1:0] MOVE_INT   = MILLIS_BITS'(500);
  localparam logic [MILLIS_BITS-1:0] MOVE_LOW   = MILLIS_BITS'(800);
  localparam logic [MILLIS_BITS-1:0] MOVE_HIGH  = MILLIS_BITS'(300);
  localparam logic [MILLIS_BITS:0]   INT_PAUSE  = (MILLIS_BITS+1)'(3000);
  localparam logic [MILLIS_BITS-1:0] MILLIS_MAX = '1;

  typedef enum logic [1:0] {
    WIPE_OFF      = 2'd0,
    WIPE_INTERMIT = 2'd1,
    WIPE_LOW      = 2'd2,
    WIPE_HIGH     = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_USE_REMOTE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_REMOTE_MODE = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SAFE    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SAFE    = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_LIMIT  = CFG_IDX_BITS'(4);

  // One classified tick handed from the front end to the sequencer.
  typedef struct packed {
    logic                   fault;
    mode_t                  mode;
    logic [SAMPLE_BITS-1:0] level;
  } item_t;

endpackage

// ===== sv/wiper_sequencer_with_sensor_check_top.sv =====
`timescale 1ns / 1ps
// Top level of the wiper sequencer with knob sensor check.
// Depends on wsc_pkg, wsc_front, wsc_fifo and wsc_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  cfg      | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[11:0]
//  in       | in_valid / in_ready    | adc_sample[11:0]
//  out      | out_valid / out_ready  | fault, mode, filtered_level, wiper_phase,
//           |                        | servo_duty, led_blue_on/green_on/red_on
//
// One transfer per clock sustained on in and out while out_ready stays high.
// A sample is checked, filtered and classified in the cycle it is taken and
// lands in a 2-entry queue; the sequencer pops one per cycle, unless out
// stalls, into the result register, so an item passes the queue slot and
// then the result register before its out transfer.
// Reset (rst, synchronous) clears the ring, the sum, the config registers to
// their defaults, the sequencer to idle at rest duty, and empties the queue.
// An out stall fills the queue; in_ready drops only once both slots hold.
// cfg_ready is always high.
module wiper_sequencer_with_sensor_check_top import wsc_pkg::*; #(
  parameter int TICK_STEP_MS = TICK_MS  // sequencer time step per tick
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DAT_BITS-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  adc_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    fault,
  output logic [1:0]              mode,
  output logic [SAMPLE_BITS-1:0]  filtered_level,
  output logic [1:0]              wiper_phase,
  output logic [DUTY_BITS-1:0]    servo_duty,
  output logic                    led_blue_on,
  output logic                    led_green_on,
  output logic                    led_red_on
);

  // front end -> queue
  logic  push;
  item_t push_item;
  logic  q_full;
  // queue -> sequencer
  logic  pop;
  logic  q_valid;
  item_t q_head;

  wsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  wsc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  wsc_back #(
    .TICK_STEP_MS (TICK_STEP_MS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .fault          (fault),
    .mode           (mode),
    .filtered_level (filtered_level),
    .wiper_phase    (wiper_phase),
    .servo_duty     (servo_duty),
    .led_blue_on    (led_blue_on),
    .led_green_on   (led_green_on),
    .led_red_on     (led_red_on)
  );

endmodule

// ===== sv/wsc_front.sv =====
`timescale 1ns / 1ps
// Front end: config registers, sensor check, moving-average ring and mode select.
// Depends on wsc_pkg.
module wsc_front import wsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DAT_BITS-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  adc_sample,
  output logic                    push,
  output item_t                   push_item,
  input  logic                    q_full
);

  logic                   use_remote;
  mode_t                  remote_mode;
  logic [SAMPLE_BITS-1:0] min_safe;
  logic [SAMPLE_BITS-1:0] max_safe;
  logic [SAMPLE_BITS-1:0] step_limit;

  logic [SAMPLE_BITS-1:0] ring [FILTER_DEPTH];
  logic [SUM_BITS-1:0]    ring_sum;
  logic [SLOT_BITS-1:0]   ring_slot;
  logic [SAMPLE_BITS-1:0] previous_raw;

  logic [SAMPLE_BITS-1:0] delta;
  logic                   fault;
  logic [SUM_BITS-1:0]    sum_next;
  logic [SAMPLE_BITS-1:0] level;
  mode_t                  knob_mode;
  mode_t                  mode;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  always_comb begin
    delta    = (adc_sample > previous_raw) ? adc_sample - previous_raw
                                           : previous_raw - adc_sample;
    fault    = (adc_sample < min_safe) || (adc_sample > max_safe) || (delta > step_limit);
    sum_next = ring_sum - SUM_BITS'(ring[ring_slot]) + SUM_BITS'(adc_sample);
    // faulty tick leaves the average where it was
    level    = fault ? ring_sum[SUM_BITS-1:SLOT_BITS] : sum_next[SUM_BITS-1:SLOT_BITS];
    priority if (level < LVL_INT)  knob_mode = WIPE_OFF;
    else if (level < LVL_LOW)      knob_mode = WIPE_INTERMIT;
    else if (level < LVL_HIGH)     knob_mode = WIPE_LOW;
    else                           knob_mode = WIPE_HIGH;
    if (fault)           mode = WIPE_OFF;
    else if (use_remote) mode = remote_mode;
    else                 mode = knob_mode;
    push_item.fault = fault;
    push_item.mode  = mode;
    push_item.level = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_remote  <= 1'b0;
      remote_mode <= WIPE_OFF;
      min_safe    <= MIN_SAFE_RST;
      max_safe    <= MAX_SAFE_RST;
      step_limit  <= STEP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_USE_REMOTE:  use_remote  <= cfg_data[0];
        REG_REMOTE_MODE: remote_mode <= mode_t'(cfg_data[1:0]);
        REG_MIN_SAFE:    min_safe    <= cfg_data[SAMPLE_BITS-1:0];
        REG_MAX_SAFE:    max_safe    <= cfg_data[SAMPLE_BITS-1:0];
        REG_STEP_LIMIT:  step_limit  <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILTER_DEPTH; i++) ring[i] <= '0;
      ring_sum     <= '0;
      ring_slot    <= '0;
      previous_raw <= '0;
    end else if (push) begin
      previous_raw <= adc_sample;
      if (!fault) begin
        ring[ring_slot] <= adc_sample;
        ring_sum        <= sum_next;
        ring_slot       <= ring_slot + SLOT_BITS'(1);
      end
    end
  end

endmodule

// ===== sv/wsc_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified ticks between front end and sequencer.
// Depends on wsc_pkg.
module wsc_fifo import wsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/wsc_back.sv =====
`timescale 1ns / 1ps
// Back end: servo sweep sequencer, LED decode and the result register.
// Depends on wsc_pkg.
module wsc_back import wsc_pkg::*; #(
  parameter int TICK_STEP_MS = TICK_MS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   fault,
  output logic [1:0]             mode,
  output logic [SAMPLE_BITS-1:0] filtered_level,
  output logic [1:0]             wiper_phase,
  output logic [DUTY_BITS-1:0]   servo_duty,
  output logic                   led_blue_on,
  output logic                   led_green_on,
  output logic                   led_red_on
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_UP   = 2'd1,
    PH_DOWN = 2'd2
  } phase_t;

  phase_t                 phase, phase_next;
  logic [MILLIS_BITS-1:0] millis, millis_next;
  logic [DUTY_BITS-1:0]   duty, duty_next;
  logic [MILLIS_BITS-1:0] dur;
  logic [MILLIS_BITS:0]   target;
  logic [MILLIS_BITS:0]   t_sum;
  logic [MILLIS_BITS-1:0] t_sat;
  phase_t                 p_start;

  assign pop         = q_valid && (!out_valid || out_ready);
  assign wiper_phase = phase;
  assign servo_duty  = duty;

  always_comb begin
    unique case (q_item.mode)
      WIPE_INTERMIT: dur = MOVE_INT;
      WIPE_LOW:      dur = MOVE_LOW;
      default:       dur = MOVE_HIGH;
    endcase
    target  = (q_item.mode == WIPE_INTERMIT) ? {1'b0, dur} + INT_PAUSE : {1'b0, dur};
    p_start = (phase == PH_IDLE) ? PH_UP : phase;
    t_sum   = ((phase == PH_IDLE) ? '0 : {1'b0, millis}) + (MILLIS_BITS+1)'(TICK_STEP_MS);
    t_sat   = t_sum[MILLIS_BITS] ? MILLIS_MAX : t_sum[MILLIS_BITS-1:0];
    phase_next  = p_start;
    millis_next = t_sat;
    duty_next   = (phase == PH_IDLE) ? DUTY_SWEEP : duty;
    if (q_item.mode == WIPE_OFF) begin
      phase_next  = PH_IDLE;
      millis_next = '0;
      duty_next   = DUTY_REST;
    end else begin
      unique case (p_start)
        PH_UP: begin
          if (t_sat >= dur) begin
            phase_next  = PH_DOWN;
            millis_next = '0;
            duty_next   = DUTY_REST;
          end
        end
        PH_DOWN: begin
          if ({1'b0, t_sat} >= target) begin
            phase_next  = PH_IDLE;
            millis_next = '0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      millis    <= '0;
      duty      <= DUTY_REST;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase     <= phase_next;
        millis    <= millis_next;
        duty      <= duty_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fault          <= q_item.fault;
      mode           <= q_item.mode;
      filtered_level <= q_item.level;
      led_blue_on    <= (q_item.mode == WIPE_INTERMIT);
      led_green_on   <= (q_item.mode == WIPE_LOW);
      led_red_on     <= (q_item.mode == WIPE_HIGH);
    end
  end

`ifndef ASSERT_OFF
  a_up_sweeps: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_UP |-> duty == DUTY_SWEEP)
    else $error("up phase without sweep duty");
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> mode == WIPE_OFF && phase == PH_IDLE)
    else $error("fault did not force mode off");
  a_off_rest: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == WIPE_OFF |-> duty == DUTY_REST && millis == '0)
    else $error("mode off but servo not at rest");
  a_leds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({led_blue_on, led_green_on, led_red_on}))
    else $error("more than one LED on");
`endif

endmodule
